// File: hdl/mpsm_pkg.sv
// Package for the multi-pattern string matcher core.
// Holds payload structs, action and status codes, FSM states and datapath ops.
// No dependencies.
package mpsm_pkg;

  // Action codes of an input item
  localparam logic [1:0] ACT_PATTERN = 2'd0;
  localparam logic [1:0] ACT_TEXT    = 2'd1;
  localparam logic [1:0] ACT_QUERY   = 2'd2;

  // Query status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] ch;
    logic       last;
    logic [7:0] pattern_index;
  } in_t;

  typedef struct packed {
    logic [7:0] result_index;
    logic       found;
    logic [1:0] status;
  } out_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISP, S_RED,
    S_P1, S_P2,
    S_T1, S_T2, S_T3, S_T4,
    S_Q1, S_Q2, S_Q3,
    S_BI, S_BPOP, S_BU, S_BF1, S_BF2, S_BF3, S_BF4, S_BF5,
    S_CRD, S_CEV, S_CWR
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_CLEAR, OP_LATCH, OP_RED,
    OP_P_RD, OP_P_EVAL,
    OP_T_RD, OP_T_SET, OP_T_WALK, OP_T_NEXT,
    OP_Q_RD, OP_Q_VIS, OP_Q_OUT,
    OP_B_INIT, OP_B_POP, OP_B_U,
    OP_F_ZERO, OP_F_RD, OP_F_SLOT, OP_F_SET, OP_F_WR, OP_D_WR,
    OP_C_RD, OP_C_EV, OP_C_WR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic       clear_done;
    logic [1:0] act;
    logic       ch_ok;
    logic       load_closed;
    logic       text_seen;
    logic       walk_go;
    logic       q_root;
    logic       p_zero;
    logic       q_nonempty;
    logic       edge_hit;
    logic       u_root;
    logic       last_c;
  } stat_t;

endpackage

// File: hdl/mpsm_ctrl.sv
// Controller FSM of the matcher: sequences loading, automaton build, walk, query.
// Depends on mpsm_pkg; talks to mpsm_dp through cmd_t / stat_t only.
module mpsm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  mpsm_pkg::stat_t stat,
  output mpsm_pkg::cmd_t  cmd,
  output logic            busy
);
  import mpsm_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (stat.clear_done) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_DISP;
      S_DISP: begin
        if (stat.act == ACT_PATTERN) state_nxt = stat.load_closed ? S_IDLE : S_RED;
        else if (stat.act == ACT_TEXT) state_nxt = S_RED;
        else if (stat.act == ACT_QUERY) state_nxt = S_Q1;
        else state_nxt = S_IDLE;
      end
      S_RED: begin
        if (stat.ch_ok) begin
          if (stat.act == ACT_PATTERN) state_nxt = S_P1;
          else state_nxt = stat.text_seen ? S_T1 : S_BI;
        end
      end
      S_P1:  state_nxt = S_P2;
      S_P2:  state_nxt = S_IDLE;
      S_T1:  state_nxt = S_T2;
      S_T2:  state_nxt = S_T3;
      S_T3:  state_nxt = S_T4;
      S_T4:  state_nxt = stat.walk_go ? S_T3 : S_IDLE;
      S_Q1:  state_nxt = S_Q2;
      S_Q2:  state_nxt = S_Q3;
      S_Q3:  state_nxt = S_IDLE;
      S_BI:  state_nxt = S_BPOP;
      S_BPOP: state_nxt = stat.q_nonempty ? S_BU : S_T1;
      S_BU:  state_nxt = stat.q_root ? S_CRD : S_BF1;
      S_BF1: state_nxt = stat.p_zero ? S_BF4 : S_BF2;
      S_BF2: state_nxt = S_BF3;
      S_BF3: state_nxt = S_BF4;
      S_BF4: state_nxt = S_BF5;
      S_BF5: state_nxt = S_CRD;
      S_CRD: state_nxt = S_CEV;
      S_CEV: begin
        if (stat.edge_hit || stat.u_root) state_nxt = stat.last_c ? S_BPOP : S_CRD;
        else state_nxt = S_CWR;
      end
      S_CWR: state_nxt = stat.last_c ? S_BPOP : S_CRD;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath command
  always_comb begin
    cmd.op = OP_NOP;
    case (state_r)
      S_CLEAR: cmd.op = OP_CLEAR;
      S_IDLE:  cmd.op = start ? OP_LATCH : OP_NOP;
      S_RED:   cmd.op = OP_RED;
      S_P1:    cmd.op = OP_P_RD;
      S_P2:    cmd.op = OP_P_EVAL;
      S_T1:    cmd.op = OP_T_RD;
      S_T2:    cmd.op = OP_T_SET;
      S_T3:    cmd.op = OP_T_WALK;
      S_T4:    cmd.op = OP_T_NEXT;
      S_Q1:    cmd.op = OP_Q_RD;
      S_Q2:    cmd.op = OP_Q_VIS;
      S_Q3:    cmd.op = OP_Q_OUT;
      S_BI:    cmd.op = OP_B_INIT;
      S_BPOP:  cmd.op = stat.q_nonempty ? OP_B_POP : OP_NOP;
      S_BU:    cmd.op = OP_B_U;
      S_BF1:   cmd.op = stat.p_zero ? OP_F_ZERO : OP_F_RD;
      S_BF2:   cmd.op = OP_F_SLOT;
      S_BF3:   cmd.op = OP_F_SET;
      S_BF4:   cmd.op = OP_F_WR;
      S_BF5:   cmd.op = OP_D_WR;
      S_CRD:   cmd.op = OP_C_RD;
      S_CEV:   cmd.op = OP_C_EV;
      S_CWR:   cmd.op = OP_C_WR;
      default: cmd.op = OP_NOP;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: hdl/mpsm_dp.sv
// Datapath of the matcher: goto/link/parent/pattern/queue/mark memories and registers.
// Depends on mpsm_pkg; driven by mpsm_ctrl commands.
module mpsm_dp #(
  parameter int MAX_NODES    = 256,
  parameter int MAX_PATTERNS = 256,
  parameter int ALPHABET     = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  input  mpsm_pkg::in_t   in_data,
  input  mpsm_pkg::cmd_t  cmd,
  output mpsm_pkg::stat_t stat,
  output logic            out_valid,
  output mpsm_pkg::out_t  out_data
);
  import mpsm_pkg::*;

  localparam int NIW = $clog2(MAX_NODES);
  localparam int NW  = $clog2(MAX_NODES + 1);
  localparam int AW  = $clog2(ALPHABET);
  localparam int GD  = MAX_NODES * ALPHABET;
  localparam int GW  = $clog2(GD);
  localparam int PW  = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int CW  = $clog2(MAX_PATTERNS + 1);
  localparam int QW  = (CW > 8) ? CW : 8;
  localparam logic [NW-1:0] NO_NODE = NW'(MAX_NODES);

  function automatic logic [GW-1:0] slot(input logic [NIW-1:0] n, input logic [AW-1:0] c);
    return GW'(n) * GW'(ALPHABET) + GW'(c);
  endfunction

  // registers
  logic [1:0]           act_r, act_nxt;
  logic [7:0]           ch_r, ch_nxt;
  logic                 last_r, last_nxt;
  logic [7:0]           pidx_r, pidx_nxt;
  logic [NIW-1:0]       load_r, load_nxt;
  logic [NIW-1:0]       match_r, match_nxt;
  logic [NW-1:0]        ncount_r, ncount_nxt;
  logic [CW-1:0]        pcount_r, pcount_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 tseen_r, tseen_nxt;
  logic [GW-1:0]        clr_r, clr_nxt;
  logic [NW-1:0]        head_r, head_nxt;
  logic [NW-1:0]        tail_r, tail_nxt;
  logic [NIW-1:0]       u_r, u_nxt;
  logic [AW-1:0]        c_r, c_nxt;
  logic [NIW-1:0]       f_r, f_nxt;
  logic [AW-1:0]        pc_r, pc_nxt;
  logic [NIW-1:0]       i_r, i_nxt;
  logic                 ov_r, ov_nxt;
  out_t                 out_r, out_nxt;

  // memory ports
  logic [NW-1:0]  goto_mem [GD];
  logic [NW-1:0]  goto_q, g_wd;
  logic [GW-1:0]  g_addr;
  logic           g_we, g_re;
  logic [NIW-1:0] fail_mem [MAX_NODES];
  logic [NIW-1:0] fail_q, fl_addr, fl_wd;
  logic           fl_we, fl_re;
  logic [NIW-1:0] dict_mem [MAX_NODES];
  logic [NIW-1:0] dict_q, dl_addr, dl_wd;
  logic           dl_we, dl_re;
  logic [NIW-1:0] pn_mem [MAX_NODES];
  logic [NIW-1:0] pn_q, pn_addr, pn_wd;
  logic [AW-1:0]  pcm_mem [MAX_NODES];
  logic [AW-1:0]  pcm_q, pcm_wd;
  logic           par_we, par_re;
  logic [NIW-1:0] pat_mem [MAX_PATTERNS];
  logic [NIW-1:0] pat_q, pat_wd;
  logic [PW-1:0]  pat_addr;
  logic           pat_we, pat_re;
  logic [NIW-1:0] que_mem [MAX_NODES];
  logic [NIW-1:0] que_q, que_addr, que_wd;
  logic           que_we, que_re;
  logic           term_mem [MAX_NODES];
  logic           term_q, term_wd, term_we, term_re;
  logic [NIW-1:0] term_addr;
  logic           vis_mem [MAX_NODES];
  logic           vis_q, vis_wd, vis_we, vis_re;
  logic [NIW-1:0] vis_addr;

  logic [NIW-1:0] cur;
  logic           in_range;

  // next-state logic per command
  always_comb begin
    act_nxt = act_r; ch_nxt = ch_r; last_nxt = last_r; pidx_nxt = pidx_r;
    load_nxt = load_r; match_nxt = match_r; ncount_nxt = ncount_r; pcount_nxt = pcount_r;
    ovf_nxt = ovf_r; tseen_nxt = tseen_r; clr_nxt = clr_r; head_nxt = head_r;
    tail_nxt = tail_r; u_nxt = u_r; c_nxt = c_r; f_nxt = f_r; pc_nxt = pc_r; i_nxt = i_r;
    ov_nxt = 1'b0; out_nxt = out_r;
    g_addr = slot(u_r, c_r); g_we = 1'b0; g_re = 1'b0; g_wd = NO_NODE;
    fl_addr = u_r; fl_wd = f_r; fl_we = 1'b0; fl_re = 1'b0;
    dl_addr = u_r; dl_wd = f_r; dl_we = 1'b0; dl_re = 1'b0;
    pn_addr = que_q; pn_wd = load_r; pcm_wd = ch_r[AW-1:0]; par_we = 1'b0; par_re = 1'b0;
    pat_addr = PW'(pidx_r); pat_wd = '0; pat_we = 1'b0; pat_re = 1'b0;
    que_addr = head_r[NIW-1:0]; que_wd = '0; que_we = 1'b0; que_re = 1'b0;
    term_addr = f_r; term_wd = 1'b0; term_we = 1'b0; term_re = 1'b0;
    vis_addr = i_r; vis_wd = 1'b1; vis_we = 1'b0; vis_re = 1'b0;
    cur = '0;
    in_range = (QW'(pidx_r) < QW'(pcount_r));
    case (cmd.op)
      // sweep the goto store to "no edge" and the mark stores to zero
      OP_CLEAR: begin
        g_addr = clr_r; g_we = 1'b1; g_wd = NO_NODE;
        term_addr = clr_r[NIW-1:0]; term_wd = 1'b0; term_we = (clr_r < GW'(MAX_NODES));
        vis_addr = clr_r[NIW-1:0]; vis_wd = 1'b0; vis_we = (clr_r < GW'(MAX_NODES));
        clr_nxt = clr_r + GW'(1);
      end
      OP_LATCH: begin
        act_nxt = in_data.action; ch_nxt = in_data.ch;
        last_nxt = in_data.last; pidx_nxt = in_data.pattern_index;
      end
      // reduce ch modulo the alphabet by repeated subtraction
      OP_RED: begin
        if ({1'b0, ch_r} >= 9'(ALPHABET)) ch_nxt = ch_r - 8'(ALPHABET);
      end
      OP_P_RD: begin
        g_addr = slot(load_r, ch_r[AW-1:0]); g_re = 1'b1;
      end
      // pattern char: follow or create edge, then close the pattern if last
      OP_P_EVAL: begin
        g_addr = slot(load_r, ch_r[AW-1:0]);
        if (goto_q == NO_NODE && ncount_r >= NW'(MAX_NODES)) begin
          ovf_nxt = 1'b1; load_nxt = '0;
        end else begin
          if (goto_q != NO_NODE) begin
            cur = goto_q[NIW-1:0];
          end else begin
            cur = ncount_r[NIW-1:0];
            ncount_nxt = ncount_r + NW'(1);
            g_we = 1'b1; g_wd = ncount_r;
            pn_addr = cur; par_we = 1'b1;
          end
          if (last_r) begin
            if (pcount_r >= CW'(MAX_PATTERNS)) begin
              ovf_nxt = 1'b1;
            end else begin
              term_addr = cur; term_wd = 1'b1; term_we = 1'b1;
              pat_addr = pcount_r[PW-1:0]; pat_wd = cur; pat_we = 1'b1;
              pcount_nxt = pcount_r + CW'(1);
            end
            load_nxt = '0;
          end else begin
            load_nxt = cur;
          end
        end
      end
      OP_T_RD: begin
        g_addr = slot(match_r, ch_r[AW-1:0]); g_re = 1'b1;
      end
      OP_T_SET: begin
        match_nxt = goto_q[NIW-1:0]; i_nxt = goto_q[NIW-1:0];
      end
      // fetch mark and dictionary link of the current chain node
      OP_T_WALK: begin
        dl_addr = i_r; dl_re = 1'b1;
        vis_addr = i_r; vis_re = 1'b1;
      end
      // mark the chain node and step, or mark the match state and stop
      OP_T_NEXT: begin
        if (stat.walk_go) begin
          vis_addr = i_r; vis_we = 1'b1;
          i_nxt = dict_q;
        end else begin
          vis_addr = match_r; vis_we = 1'b1;
        end
      end
      OP_Q_RD: pat_re = 1'b1;
      OP_Q_VIS: begin
        vis_addr = in_range ? pat_q : '0; vis_re = 1'b1;
      end
      OP_Q_OUT: begin
        ov_nxt = 1'b1;
        out_nxt.result_index = pidx_r;
        out_nxt.found = in_range & vis_q;
        out_nxt.status = ovf_r ? ST_OVERFLOW : (!in_range ? ST_RANGE : ST_OK);
      end
      // breadth-first completion of the automaton
      OP_B_INIT: begin
        tseen_nxt = 1'b1;
        que_addr = '0; que_wd = '0; que_we = 1'b1;
        head_nxt = '0; tail_nxt = NW'(1);
        dl_addr = '0; dl_wd = '0; dl_we = 1'b1;
      end
      OP_B_POP: begin
        que_re = 1'b1; head_nxt = head_r + NW'(1);
      end
      OP_B_U: begin
        u_nxt = que_q; c_nxt = '0;
        pn_addr = que_q; par_re = 1'b1;
      end
      OP_F_ZERO: f_nxt = '0;
      OP_F_RD: begin
        fl_addr = pn_q; fl_re = 1'b1; pc_nxt = pcm_q;
      end
      OP_F_SLOT: begin
        g_addr = slot(fail_q, pc_r); g_re = 1'b1;
      end
      OP_F_SET: f_nxt = goto_q[NIW-1:0];
      OP_F_WR: begin
        fl_addr = u_r; fl_wd = f_r; fl_we = 1'b1;
        dl_addr = f_r; dl_re = 1'b1;
        term_addr = f_r; term_re = 1'b1;
      end
      OP_D_WR: begin
        dl_addr = u_r; dl_wd = term_q ? f_r : dict_q; dl_we = 1'b1;
        c_nxt = '0;
      end
      OP_C_RD: begin
        g_addr = slot(u_r, c_r); g_re = 1'b1;
      end
      OP_C_EV: begin
        if (goto_q != NO_NODE) begin
          if (tail_r < NW'(MAX_NODES)) begin
            que_addr = tail_r[NIW-1:0]; que_wd = goto_q[NIW-1:0]; que_we = 1'b1;
            tail_nxt = tail_r + NW'(1);
          end
          c_nxt = c_r + AW'(1);
        end else if (u_r == '0) begin
          g_addr = slot(u_r, c_r); g_we = 1'b1; g_wd = '0;
          c_nxt = c_r + AW'(1);
        end else begin
          g_addr = slot(f_r, c_r); g_re = 1'b1;
        end
      end
      OP_C_WR: begin
        g_addr = slot(u_r, c_r); g_we = 1'b1; g_wd = goto_q;
        c_nxt = c_r + AW'(1);
      end
      default: ;
    endcase
  end

  // status to controller
  always_comb begin
    stat.clear_done  = (clr_r == GW'(GD - 1));
    stat.act         = act_r;
    stat.ch_ok       = ({1'b0, ch_r} < 9'(ALPHABET));
    stat.load_closed = tseen_r | ovf_r;
    stat.text_seen   = tseen_r;
    stat.walk_go     = (i_r != '0) && !vis_q;
    stat.q_root      = (que_q == '0);
    stat.p_zero      = (pn_q == '0);
    stat.q_nonempty  = (head_r < tail_r);
    stat.edge_hit    = (goto_q != NO_NODE);
    stat.u_root      = (u_r == '0);
    stat.last_c      = (c_r == AW'(ALPHABET - 1));
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r <= '0; match_r <= '0; ncount_r <= NW'(1); pcount_r <= '0;
      ovf_r <= 1'b0; tseen_r <= 1'b0; clr_r <= '0; head_r <= '0; tail_r <= '0;
      ov_r <= 1'b0;
    end else begin
      load_r <= load_nxt; match_r <= match_nxt; ncount_r <= ncount_nxt;
      pcount_r <= pcount_nxt; ovf_r <= ovf_nxt; tseen_r <= tseen_nxt; clr_r <= clr_nxt;
      head_r <= head_nxt; tail_r <= tail_nxt;
      ov_r <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_r <= act_nxt; ch_r <= ch_nxt; last_r <= last_nxt; pidx_r <= pidx_nxt;
    u_r <= u_nxt; c_r <= c_nxt; f_r <= f_nxt; pc_r <= pc_nxt; i_r <= i_nxt;
    out_r <= out_nxt;
  end

  // memories, registered reads
  always_ff @(posedge clk) begin
    if (g_we) goto_mem[g_addr] <= g_wd;
    if (g_re) goto_q <= goto_mem[g_addr];
  end
  always_ff @(posedge clk) begin
    if (fl_we) fail_mem[fl_addr] <= fl_wd;
    if (fl_re) fail_q <= fail_mem[fl_addr];
  end
  always_ff @(posedge clk) begin
    if (dl_we) dict_mem[dl_addr] <= dl_wd;
    if (dl_re) dict_q <= dict_mem[dl_addr];
  end
  always_ff @(posedge clk) begin
    if (par_we) begin
      pn_mem[pn_addr]  <= pn_wd;
      pcm_mem[pn_addr] <= pcm_wd;
    end
    if (par_re) begin
      pn_q  <= pn_mem[pn_addr];
      pcm_q <= pcm_mem[pn_addr];
    end
  end
  always_ff @(posedge clk) begin
    if (pat_we) pat_mem[pat_addr] <= pat_wd;
    if (pat_re) pat_q <= pat_mem[pat_addr];
  end
  always_ff @(posedge clk) begin
    if (que_we) que_mem[que_addr] <= que_wd;
    if (que_re) que_q <= que_mem[que_addr];
  end
  always_ff @(posedge clk) begin
    if (term_we) term_mem[term_addr] <= term_wd;
    if (term_re) term_q <= term_mem[term_addr];
  end
  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_addr] <= vis_wd;
    if (vis_re) vis_q <= vis_mem[vis_addr];
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

endmodule

// File: hdl/multi_pattern_string_matcher_core.sv
// Top level of the Aho-Corasick multi-pattern string matcher.
// Depends on mpsm_pkg, mpsm_ctrl and mpsm_dp.
//
// Channel  Ports                     Transfer when
// input    start, busy, in_data      start high and busy low at a rising edge
// result   out_valid, out_data       out_valid high, one cycle, no backpressure
//
// Pattern char: latch, dispatch, reduce, goto read, evaluate. Query: latch,
// dispatch, pattern read, mark read, output; result the cycle after output.
// Text char: latch, dispatch, reduce, goto read, match set, then fetch and mark
// per dictionary node newly marked; the first one also builds the automaton.
// Ignored loads, unknown actions: latch, dispatch. A char at or above ALPHABET adds
// a reduce step per subtraction. After reset goto and mark memories are swept, busy high.
module multi_pattern_string_matcher_core #(
  parameter int MAX_NODES    = 256,
  parameter int MAX_PATTERNS = 256,
  parameter int ALPHABET     = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  mpsm_pkg::in_t  in_data,
  output logic           out_valid,
  output mpsm_pkg::out_t out_data
);
  import mpsm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mpsm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  mpsm_dp #(
    .MAX_NODES    (MAX_NODES),
    .MAX_PATTERNS (MAX_PATTERNS),
    .ALPHABET     (ALPHABET)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
